// ----- rtl/text_console_writer_core_macros.svh -----
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// Constants and types shared by the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'd7;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, SPACE_CODE};

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_data;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

endpackage

// ----- rtl/text_console_writer_core.sv -----
// Text console writer top level: cursor control, scrolling and screen access.
//
// Keeps a 25x80 screen of 16-bit cells (attribute high, character low) in one
// synchronous RAM plus the cursor. After reset a clearing pass writes blanks to
// all 2000 cells, one per cycle, and cmd_ready stays low until that pass ends.
// A put passes through S_ADDR, S_WRITE and S_RESULT, a newline through S_ADDR
// and S_RESULT and a read-back through S_READ and S_RESULT; the result is
// registered in S_RESULT and the next command transfers back in S_IDLE.
// Scrolling rotates a row offset and blanks one row in S_SCROLL, which comes
// before S_ADDR for the put that triggers it. The result sits in an output
// register, so the next command transfers while a result still waits on rsp_ready;
// a result that finds the register still full waits until it drains.
`timescale 1ns / 1ps
`include "text_console_writer_core_macros.svh"

module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_READ,
    S_ADDR,
    S_WRITE,
    S_RESULT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] cnt;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] base_off;
  logic [ATTR_W-1:0] text_attribute;
  logic [CHAR_W-1:0] put_char;
  logic              rd_ok;
  logic [CELL_W-1:0] cell_data;
  logic [ADDR_W-1:0] lin;

  ram_wr_t           wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic              accept;
  logic              idx_ok;
  logic              wrap;
  logic [ROW_W-1:0]  row_w;
  logic [COL_W-1:0]  col_w;
  logic [ADDR_W-1:0] pos;

  // logical cell offset plus row rotation, folded into the screen range
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] a,
                                             input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign idx_ok    = (cmd.cell_index < ADDR_W'(CELLS));
  assign rd_en     = accept && (cmd.mode == MODE_READ) && idx_ok;
  assign rd_addr   = phys(cmd.cell_index, base_off);

  assign wrap  = (cur_col >= COL_W'(COLS));
  assign row_w = wrap ? cur_row + ROW_W'(1) : cur_row;
  assign col_w = wrap ? '0 : cur_col;
  assign pos   = ADDR_W'(cur_row) * ADDR_W'(COLS) + ADDR_W'(cur_col);

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = cnt;
    wr.data = BLANK_CELL;
    unique case (state)
      S_CLEAR: begin
        wr.en = 1'b1;
      end
      S_SCROLL: begin
        wr.en   = 1'b1;
        wr.addr = base_off + cnt;
      end
      S_WRITE: begin
        wr.en   = 1'b1;
        wr.addr = phys(lin, base_off);
        wr.data = {text_attribute, put_char};
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  tcw_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cnt            <= '0;
      cur_row        <= '0;
      cur_col        <= '0;
      base_off       <= '0;
      text_attribute <= ATTR_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_attribute <= cfg_wdata;
      end
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            put_char  <= cmd.char_code;
            rd_ok     <= idx_ok;
            cell_data <= '0;
            if (cmd.mode == MODE_READ) begin
              state <= S_READ;
            end else if (row_w >= ROW_W'(ROWS)) begin
              cur_row <= ROW_W'(ROWS - 1);
              cur_col <= col_w;
              cnt     <= '0;
              state   <= S_SCROLL;
            end else begin
              cur_row <= row_w;
              cur_col <= col_w;
              state   <= S_ADDR;
            end
          end
        end
        S_SCROLL: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(COLS - 1)) begin
            base_off <= (base_off == ADDR_W'(CELLS - COLS)) ? '0 : base_off + ADDR_W'(COLS);
            state    <= S_ADDR;
          end
        end
        S_READ: begin
          cell_data <= rd_ok ? rd_data : '0;
          state     <= S_RESULT;
        end
        S_ADDR: begin
          if (put_char == NEWLINE_CODE) begin
            cur_col <= '0;
            cur_row <= cur_row + ROW_W'(1);
            state   <= S_RESULT;
          end else begin
            lin   <= pos;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          cur_col <= cur_col + COL_W'(1);
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.cursor_row      <= cur_row;
            rsp.cursor_col      <= cur_col;
            rsp.cursor_position <= pos;
            rsp.cell_data       <= cell_data;
            rsp_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT(a_wr_range, wr.en |-> (wr.addr < ADDR_W'(CELLS)), "RAM write out of range")
  `TCW_ASSERT(a_base_range, base_off < ADDR_W'(CELLS), "row offset out of range")
  `TCW_ASSERT(a_scroll_col, (cur_row == ROW_W'(ROWS)) |-> (cur_col == '0), "scroll with column")
  `TCW_ASSERT_NEXT(a_one_item, accept, !cmd_ready, "second command taken while busy")

endmodule

// ----- rtl/tcw_screen_ram.sv -----
// Screen cell memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_screen_ram import tcw_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench for text_console_writer_core: directed and random commands scored against a screen model.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  class screen_tracker;
    logic [CELL_W-1:0] cells [CELLS];
    int row;
    int col;
    logic [ATTR_W-1:0] attribute;
    rsp_t pending_reports[$];
    int fail_count;

    function new();
      foreach (cells[i]) cells[i] = BLANK_CELL;
      row = 0;
      col = 0;
      attribute = ATTR_RESET;
      fail_count = 0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attribute = value;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void take_command(cmd_t c);
      rsp_t r;
      r = '0;
      if (c.mode == MODE_PUT) begin
        if (col >= COLS) begin
          col = 0;
          row++;
        end
        if (row >= ROWS) begin
          // scroll up one line, bottom line blank in the default attribute
          row = ROWS - 1;
          for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = BLANK_CELL;
        end
        if (c.char_code == NEWLINE_CODE) begin
          col = 0;
          row++;
        end else begin
          cells[row * COLS + col] = {attribute, c.char_code};
          col++;
        end
      end else if (c.cell_index < CELLS) begin
        r.cell_data = cells[c.cell_index];
      end
      r.cursor_row      = ROW_W'(row);
      r.cursor_col      = COL_W'(col);
      r.cursor_position = ADDR_W'(row * COLS + col);
      pending_reports.push_back(r);
    endfunction

    function void check_report(rsp_t got);
      rsp_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected response transfer: row %0d col %0d pos %0d data %h",
               got.cursor_row, got.cursor_col, got.cursor_position, got.cell_data);
        fail_count++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        fail_count++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        fail_count++;
      end
      if (got.cursor_position !== want.cursor_position) begin
        $error("cursor_position: expected %0d, got %0d",
               want.cursor_position, got.cursor_position);
        fail_count++;
      end
      if (got.cell_data !== want.cell_data) begin
        $error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  cmd_t              cmd = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  screen_tracker tracker = new();

  text_console_writer_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) tracker.take_command(cmd);
      if (rsp_valid && rsp_ready) tracker.check_report(rsp);
    end
  end

  initial begin
    #5_000_000;
    $display("** text_console_writer_core: FAILED **");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    cmd_t c;
    c.mode = MODE_PUT;
    c.char_code = ch;
    c.cell_index = ADDR_W'($urandom);
    send_cmd(c);
  endtask

  task automatic read_cell(input logic [ADDR_W-1:0] idx);
    cmd_t c;
    c.mode = MODE_READ;
    c.char_code = CHAR_W'($urandom);
    c.cell_index = idx;
    send_cmd(c);
  endtask

  task automatic wait_drain(input int tail);
    cmd_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.set_attribute(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int style;
    int burst_left;
    int nl_pct;
    int pick;
    logic [ATTR_W-1:0] phase_attr [4];

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    write_attribute(8'hFF);
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'(CELLS - 1));
    read_cell(ADDR_W'(CELLS));
    read_cell(11'h7FF);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(8'h7F);
    put_char(NEWLINE_CODE);
    put_char(8'h20);
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'(1));
    read_cell(ADDR_W'(2));
    read_cell(ADDR_W'(3));
    read_cell(ADDR_W'(4));
    read_cell(ADDR_W'(COLS));
    wait_drain(10);
    write_attribute(8'h00);
    put_char(8'h7A);
    put_char(NEWLINE_CODE);
    read_cell(ADDR_W'(COLS + 1));
    read_cell(ADDR_W'(COLS + 2));

    // random part: bursts of plain text, newline floods and long wrapping lines
    phase_attr[0] = ATTR_RESET;
    phase_attr[1] = ATTR_W'($urandom);
    phase_attr[2] = 8'hF0;
    phase_attr[3] = ATTR_W'($urandom);
    style = 0;
    burst_left = 0;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drain(10);
      write_attribute(phase_attr[phase]);
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
        default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
      endcase
      for (int n = 0; n < 150; n++) begin
        if (burst_left == 0) begin
          style = $urandom_range(2);
          burst_left = $urandom_range(120, 20);
        end
        burst_left--;
        if (phase == 2 && n == 75) wait_drain(0);
        case (style)
          0: nl_pct = 10;
          1: nl_pct = 60;
          default: nl_pct = 0;
        endcase
        if ($urandom_range(99) < 20) begin
          pick = $urandom_range(3);
          if (pick == 0) read_cell(ADDR_W'($urandom));
          else if (pick == 1) read_cell(ADDR_W'($urandom_range(CELLS - 1, CELLS - 3 * COLS)));
          else read_cell(ADDR_W'($urandom_range(CELLS - 1)));
        end else if ($urandom_range(99) < nl_pct) begin
          put_char(NEWLINE_CODE);
        end else if ($urandom_range(99) < 15) begin
          put_char(CHAR_W'($urandom));
        end else begin
          put_char(CHAR_W'($urandom_range(8'h7E, 8'h20)));
        end
      end
    end

    wait_drain(100);
    if (tracker.fail_count == 0) begin
      $display("** text_console_writer_core: PASSED **");
    end else begin
      $display("** text_console_writer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- text_console_writer_core.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer_core.sv
tb/testbench.sv
